>>> rtl/motor_command_frame_parser_unit_defines.svh
// Assertion macros for the motor command frame parser RTL.
// Define ASSERT_OFF to compile every check out; no other dependencies.
`ifndef MOTOR_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked property, disabled while reset is asserted.
`define MCFP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Combinational condition that must never be true out of reset.
`define MCFP_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define MCFP_ASSERT(lbl, clk, rstn, prop, msg)
`define MCFP_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

>>> rtl/mcfp_pkg.sv
// Shared constants and types for the motor command frame parser.
// No dependencies.
package mcfp_pkg;

	localparam logic [7:0] SyncByte  = 8'hFF;
	// byte positions inside a frame
	localparam logic [3:0] PosAfterSync = 4'd1;
	localparam logic [3:0] PosAngleHi   = 4'd2;
	localparam logic [3:0] PosScale     = 4'd7;
	localparam logic [3:0] PosChk       = 4'd8;
	localparam logic [3:0] PosLast      = 4'd9;
	localparam int         StoreFirst   = 2;
	localparam int         StoreLast    = 8;

	// frame seen by the output stage on the last byte
	typedef struct packed {
		logic        done;    // this word completes a frame
		logic        ok;      // checksum and inverted checksum match
		logic [15:0] angle;
		logic [7:0]  prop;
		logic [7:0]  integ;
		logic [7:0]  deriv;
		logic [7:0]  scale;
	} frame_t;

endpackage

>>> rtl/mcfp_assembler.sv
// Frame assembler: byte position, sync realignment, frame bytes, running checksum.
// Depends on mcfp_pkg and motor_command_frame_parser_unit_defines.svh.
`include "motor_command_frame_parser_unit_defines.svh"

module mcfp_assembler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,   // word in rx_byte is consumed this cycle
	input  logic [7:0]          rx_byte,
	output mcfp_pkg::frame_t    frame
);

	logic [3:0] pos_q;
	logic [7:0] prev_q;
	logic [7:0] sum_q;
	logic [7:0] store_q [mcfp_pkg::StoreFirst:mcfp_pkg::StoreLast];

	logic       realign;
	logic [3:0] pos_eff;

	assign realign = (rx_byte == mcfp_pkg::SyncByte) && (prev_q == mcfp_pkg::SyncByte);
	assign pos_eff = realign ? mcfp_pkg::PosAfterSync : pos_q;

	always_comb begin
		frame.done  = (pos_eff >= mcfp_pkg::PosLast);
		frame.ok    = (store_q[mcfp_pkg::StoreLast] == sum_q) && (rx_byte == ~sum_q);
		frame.angle = {store_q[2], store_q[3]};
		frame.prop  = store_q[4];
		frame.integ = store_q[5];
		frame.deriv = store_q[6];
		frame.scale = store_q[7];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= '0;
			sum_q  <= '0;
		end else if (advance) begin
			prev_q <= rx_byte;
			pos_q  <= frame.done ? '0 : pos_eff + 4'd1;
			if (pos_eff == mcfp_pkg::PosAngleHi) begin
				sum_q <= rx_byte;
			end else if (pos_eff > mcfp_pkg::PosAngleHi && pos_eff <= mcfp_pkg::PosScale) begin
				sum_q <= sum_q + rx_byte;
			end
		end
	end

	// frame bytes 2..8, each at its own place; reset value is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = mcfp_pkg::StoreFirst; i <= mcfp_pkg::StoreLast; i++) begin
				store_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = mcfp_pkg::StoreFirst; i <= mcfp_pkg::StoreLast; i++) begin
				if (pos_eff == 4'(i)) begin
					store_q[i] <= rx_byte;
				end
			end
		end
	end

	`MCFP_NEVER(a_pos_range, clk, arst_n, pos_q > mcfp_pkg::PosLast, "position left 0..9")
	`MCFP_ASSERT(a_wrap, clk, arst_n, advance && frame.done |=> pos_q == '0, "no wrap after frame")
	`MCFP_ASSERT(a_realign, clk, arst_n, advance && realign |=> pos_q == 4'd2, "realign missed")
	`MCFP_NEVER(a_realign_done, clk, arst_n, realign && frame.done, "realign completed frame")

endmodule

>>> rtl/mcfp_output.sv
// Result register: held command values, pass flag and output valid.
// Depends on mcfp_pkg and motor_command_frame_parser_unit_defines.svh.
`include "motor_command_frame_parser_unit_defines.svh"

module mcfp_output (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,      // completed frame enters the register
	input  mcfp_pkg::frame_t frame,
	input  logic             taken,     // downstream accepted the result word
	output logic             valid,
	output logic [15:0]      angle,
	output logic [7:0]       prop_gain,
	output logic [7:0]       integ_gain,
	output logic [7:0]       deriv_gain,
	output logic [7:0]       gain_scale,
	output logic             frame_ok
);

	logic        valid_q;
	logic        ok_q;
	logic [15:0] angle_q;
	logic [7:0]  prop_q;
	logic [7:0]  integ_q;
	logic [7:0]  deriv_q;
	logic [7:0]  scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ok_q    <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			ok_q    <= frame.ok;
		end else if (taken) begin
			valid_q <= 1'b0;
		end
	end

	// held values double as the result payload; they only move on a good frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			prop_q  <= '0;
			integ_q <= '0;
			deriv_q <= '0;
			scale_q <= '0;
		end else if (load && frame.ok) begin
			angle_q <= frame.angle;
			prop_q  <= frame.prop;
			integ_q <= frame.integ;
			deriv_q <= frame.deriv;
			scale_q <= frame.scale;
		end
	end

	assign valid      = valid_q;
	assign angle      = angle_q;
	assign prop_gain  = prop_q;
	assign integ_gain = integ_q;
	assign deriv_gain = deriv_q;
	assign gain_scale = scale_q;
	assign frame_ok   = ok_q;

	`MCFP_ASSERT(a_hold_bad, clk, arst_n, !(load && frame.ok) |=> $stable(angle_q) && $stable(scale_q), "held values moved without good frame")
	`MCFP_ASSERT(a_load_ok, clk, arst_n, load |=> valid_q && (ok_q == $past(frame.ok)), "result flag not loaded")
	`MCFP_NEVER(a_overwrite, clk, arst_n, load && valid_q && !taken, "pending result overwritten")

endmodule

>>> rtl/motor_command_frame_parser_unit.sv
// Top level of the motor command frame parser: input register, assembler, result register.
// Depends on mcfp_pkg, mcfp_assembler, mcfp_output and the defines header.
//
// channel | dir | tdata                       | tuser    | word
// s_axis  | in  | [7:0] rx_byte               | -        | one received serial byte
// m_axis  | out | angle, prop, integ, deriv,  | frame_ok | one result per 10-byte frame
//         |     | scale (see port comments)   |          |
//
// Cycles: one word accepted per clock when not stalled (see Stalls); the result word is
//   valid from the edge at which the tenth byte leaves the input register.
// The per-byte path is the sync compare, position update and 8-bit running sum.
// Reset (arst_n low): position, previous byte, frame bytes and held values go to zero.
// Stalls: only a frame-completing word waits in the input register while a result
//   is pending and m_tready is low; all other words pass regardless of the output.
`include "motor_command_frame_parser_unit_defines.svh"

module motor_command_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // [15:0] angle, [23:16] prop_gain, [31:24] integ_gain,
	                                // [39:32] deriv_gain, [47:40] gain_scale
	output logic        m_tuser     // [0] frame_ok
);

	logic             byte_valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             out_valid;
	logic             out_taken;
	mcfp_pkg::frame_t frame;

	logic [15:0] angle;
	logic [7:0]  prop_gain;
	logic [7:0]  integ_gain;
	logic [7:0]  deriv_gain;
	logic [7:0]  gain_scale;
	logic        frame_ok;

	assign out_taken = out_valid && m_tready;

	// a word moves on unless it finishes a frame and the result slot is busy
	assign advance  = byte_valid_s1 && (!frame.done || !out_valid || m_tready);
	assign s_tready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	mcfp_assembler u_asm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.frame   (frame)
	);

	mcfp_output u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && frame.done),
		.frame      (frame),
		.taken      (out_taken),
		.valid      (out_valid),
		.angle      (angle),
		.prop_gain  (prop_gain),
		.integ_gain (integ_gain),
		.deriv_gain (deriv_gain),
		.gain_scale (gain_scale),
		.frame_ok   (frame_ok)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {gain_scale, deriv_gain, integ_gain, prop_gain, angle};
	assign m_tuser  = frame_ok;

	`MCFP_ASSERT(a_stall_done, clk, arst_n, byte_valid_s1 && frame.done && out_valid && !m_tready |-> !s_tready, "completing word not held")
	`MCFP_ASSERT(a_pass_nodone, clk, arst_n, byte_valid_s1 && !frame.done |-> s_tready, "non-final word stalled")
	`MCFP_ASSERT(a_result_follows, clk, arst_n, advance && frame.done |=> m_tvalid, "result missing after frame")

endmodule
